/* rtl/mmac_pkg.sv */
// Shared types, codes, constants and coefficient functions of the attitude controller.
`timescale 1ns / 1ps
`default_nettype none

package mmac_pkg;

   // Default data format: Q16.16 signed.
   localparam int MMAC_DATA_WIDTH = 32;
   localparam int MMAC_FRAC_BITS  = 16;

   // Register file layout.
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int MODE_W      = 3;
   localparam int PERIOD_W    = 10;
   localparam int GAIN_W      = 31;

   localparam logic [CSR_IDX_W-1:0] REG_LAW_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN     = 2'd2;

   // Control law codes; the unused code behaves as open loop.
   localparam logic [MODE_W-1:0] MODE_OPEN     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SPEED    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PI       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEAD     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LEADLAG  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SFB      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SFB_INT  = 3'd6;

   // Register reset values.
   localparam logic [MODE_W-1:0]   RESET_MODE   = MODE_OPEN;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD = 10'd10;
   localparam logic [GAIN_W-1:0]   RESET_GAIN   = 31'd65536;

   // Shared multiplier: coefficients are taken 16 bits a step, two steps.
   localparam int COEF_W      = 32;
   localparam int MUL_DIGIT_W = 16;

   // Period scaling divider: four quotient bits a cycle, divisor 2000.
   localparam int DIV_DIGIT_W = 4;
   localparam int DIV_R_W     = 11;
   localparam logic [DIV_R_W-1:0] DIV_DIVISOR = 11'd2000;

   // Speed loop gain.
   localparam int SPEED_GAIN = 12;

   // Term index width (up to five product terms per law).
   localparam int TERM_IDX_W = 3;

   // Register field group from the register file.
   typedef struct packed {
      logic [MODE_W-1:0]   law_mode;
      logic [PERIOD_W-1:0] period_ms;
      logic [GAIN_W-1:0]   integral_gain;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_LOAD,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_DONE,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_UPDATE,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_LOAD,
      MUL_LO,
      MUL_HI,
      MUL_DONE
   } mul_op_type;

   typedef enum logic [1:0] {
      DIV_NONE,
      DIV_LOAD,
      DIV_RUN
   } div_op_type;

   // Multiplier data operand.
   typedef enum logic [3:0] {
      A_E,
      A_E1,
      A_E2,
      A_C1,
      A_C2,
      A_SP,
      A_POS,
      A_RATE,
      A_INTEG
   } asel_type;

   // Multiplier coefficient operand.
   typedef enum logic [3:0] {
      B_KI,
      B_LEAD_A,
      B_LEAD_B,
      B_LEAD_C,
      B_LL_A,
      B_LL_B,
      B_LL_C,
      B_LL_D,
      B_LL_E,
      B_SF_KP,
      B_SF_KV,
      B_SI_KI,
      B_SI_KP,
      B_SI_KV,
      B_SI_RATIO
   } bsel_type;

   // Where a finished product goes.
   typedef enum logic [1:0] {
      D_ADD,
      D_SUB,
      D_U,
      D_INTEG
   } dest_type;

   typedef struct packed {
      asel_type a_sel;
      bsel_type b_sel;
      dest_type dest;
      logic     last;
   } term_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic       load;
      logic       prep;
      mul_op_type mul_op;
      asel_type   a_sel;
      bsel_type   b_sel;
      dest_type   dest;
      div_op_type div_op;
      logic       update;
      logic       finish;
   } dp_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic div_last;
      logic e_over;
      logic out_free;
   } dp_status_type;

   // Decimal constant n/10000 rounded to nearest at frac fractional bits.
   function automatic longint qc(input longint n, input int frac);
      return ((n << frac) + 64'sd5000) / 64'sd10000;
   endfunction

   // Ratio 13.6236/18.8082 rounded to nearest at frac fractional bits.
   function automatic longint si_ratio(input int frac);
      return ((64'sd136236 << frac) + 64'sd94041) / 64'sd188082;
   endfunction

   // Product term list of each law.
   function automatic term_type term_of(input logic [MODE_W-1:0] mode,
                                        input logic [TERM_IDX_W-1:0] idx);
      term_type t;
      t = '{a_sel: A_E, b_sel: B_KI, dest: D_U, last: 1'b1};
      case (mode)
         MODE_PI: begin
            t = '{a_sel: A_E, b_sel: B_KI, dest: D_U, last: 1'b1};
         end
         MODE_LEAD: begin
            case (idx)
               3'd0:    t = '{a_sel: A_E,  b_sel: B_LEAD_A, dest: D_ADD, last: 1'b0};
               3'd1:    t = '{a_sel: A_E1, b_sel: B_LEAD_B, dest: D_SUB, last: 1'b0};
               default: t = '{a_sel: A_C1, b_sel: B_LEAD_C, dest: D_ADD, last: 1'b1};
            endcase
         end
         MODE_LEADLAG: begin
            case (idx)
               3'd0:    t = '{a_sel: A_E,  b_sel: B_LL_A, dest: D_ADD, last: 1'b0};
               3'd1:    t = '{a_sel: A_E1, b_sel: B_LL_B, dest: D_SUB, last: 1'b0};
               3'd2:    t = '{a_sel: A_E2, b_sel: B_LL_C, dest: D_ADD, last: 1'b0};
               3'd3:    t = '{a_sel: A_C1, b_sel: B_LL_D, dest: D_ADD, last: 1'b0};
               default: t = '{a_sel: A_C2, b_sel: B_LL_E, dest: D_SUB, last: 1'b1};
            endcase
         end
         MODE_SFB: begin
            case (idx)
               3'd0:    t = '{a_sel: A_E,    b_sel: B_SF_KP, dest: D_ADD, last: 1'b0};
               default: t = '{a_sel: A_RATE, b_sel: B_SF_KV, dest: D_SUB, last: 1'b1};
            endcase
         end
         MODE_SFB_INT: begin
            case (idx)
               3'd0:    t = '{a_sel: A_SP,    b_sel: B_SI_RATIO, dest: D_INTEG, last: 1'b0};
               3'd1:    t = '{a_sel: A_INTEG, b_sel: B_SI_KI,    dest: D_ADD,   last: 1'b0};
               3'd2:    t = '{a_sel: A_POS,   b_sel: B_SI_KP,    dest: D_SUB,   last: 1'b0};
               default: t = '{a_sel: A_RATE,  b_sel: B_SI_KV,    dest: D_SUB,   last: 1'b1};
            endcase
         end
         default: begin
            t = '{a_sel: A_E, b_sel: B_KI, dest: D_U, last: 1'b1};
         end
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* rtl/mmac_csr.sv */
// Register file of the attitude controller behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module mmac_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mmac_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mmac_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mmac_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   output mmac_pkg::cfg_type                     cfg
);
   import mmac_pkg::*;

   logic [MODE_W-1:0]   law_mode_ff, law_mode_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic                wr_en;
   logic [CSR_IDX_W-1:0] reg_idx;

   // Registers are word aligned; the index is the word address.
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Write decode.
   always_comb begin
      law_mode_in = law_mode_ff;
      period_in   = period_ff;
      gain_in     = gain_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LAW_MODE: law_mode_in = csr_pwdata[MODE_W-1:0];
            REG_PERIOD:   period_in   = csr_pwdata[PERIOD_W-1:0];
            REG_GAIN:     gain_in     = csr_pwdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         law_mode_ff <= RESET_MODE;
         period_ff   <= RESET_PERIOD;
         gain_ff     <= RESET_GAIN;
      end else begin
         law_mode_ff <= law_mode_in;
         period_ff   <= period_in;
         gain_ff     <= gain_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_idx)
         REG_LAW_MODE: csr_prdata = CSR_DATA_W'(law_mode_ff);
         REG_PERIOD:   csr_prdata = CSR_DATA_W'(period_ff);
         REG_GAIN:     csr_prdata = CSR_DATA_W'(gain_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.law_mode      = law_mode_ff;
   assign cfg.period_ms     = period_ff;
   assign cfg.integral_gain = gain_ff;

endmodule

`default_nettype wire

/* rtl/mmac_ctrl.sv */
// Sequencer of the attitude controller: steps each law through the shared datapath.
`timescale 1ns / 1ps
`default_nettype none

module mmac_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mmac_pkg::MODE_W-1:0]        law_mode,
   input  mmac_pkg::dp_status_type            status,
   output mmac_pkg::dp_cmd_type               cmd
);
   import mmac_pkg::*;

   ctrl_state_type              state_ff, state_in;
   logic [TERM_IDX_W-1:0]       term_idx_ff, term_idx_in;
   term_type                    term;

   assign term = term_of(law_mode, term_idx_ff);

   // Next state and term index.
   always_comb begin
      state_in    = state_ff;
      term_idx_in = term_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            term_idx_in = '0;
            case (law_mode)
               MODE_PI, MODE_LEAD, MODE_LEADLAG, MODE_SFB: state_in = ST_MUL_LOAD;
               MODE_SFB_INT:                               state_in = ST_DIV_LOAD;
               default:                                    state_in = ST_FINISH;
            endcase
         end
         ST_MUL_LOAD: state_in = ST_MUL_LO;
         ST_MUL_LO:   state_in = ST_MUL_HI;
         ST_MUL_HI:   state_in = ST_MUL_DONE;
         ST_MUL_DONE: begin
            if (!term.last) begin
               term_idx_in = term_idx_ff + 1'b1;
               state_in    = ST_MUL_LOAD;
            end else if (law_mode == MODE_PI) begin
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (status.div_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // The integrating law replaces its integrator on a large error.
            if (law_mode == MODE_SFB_INT) begin
               term_idx_in = status.e_over ? TERM_IDX_W'(0) : TERM_IDX_W'(1);
               state_in    = ST_MUL_LOAD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         term_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         term_idx_ff <= term_idx_in;
      end
   end

   // Datapath commands.
   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.prep   = (state_ff == ST_PREP);
      cmd.a_sel  = term.a_sel;
      cmd.b_sel  = term.b_sel;
      cmd.dest   = term.dest;
      cmd.update = (state_ff == ST_UPDATE);
      cmd.finish = (state_ff == ST_FINISH) && status.out_free;
      unique case (state_ff)
         ST_MUL_LOAD: cmd.mul_op = MUL_LOAD;
         ST_MUL_LO:   cmd.mul_op = MUL_LO;
         ST_MUL_HI:   cmd.mul_op = MUL_HI;
         ST_MUL_DONE: cmd.mul_op = MUL_DONE;
         default:     cmd.mul_op = MUL_NONE;
      endcase
      unique case (state_ff)
         ST_DIV_LOAD: cmd.div_op = DIV_LOAD;
         ST_DIV_RUN:  cmd.div_op = DIV_RUN;
         default:     cmd.div_op = DIV_NONE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/mmac_dp.sv */
// Datapath of the attitude controller: history, shared multiplier, period divider, output.
`timescale 1ns / 1ps
`default_nettype none

module mmac_dp #(
   parameter int DATA_WIDTH = mmac_pkg::MMAC_DATA_WIDTH,
   parameter int FRAC_BITS  = mmac_pkg::MMAC_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mmac_pkg::cfg_type             cfg,
   input  mmac_pkg::dp_cmd_type          cmd,
   output mmac_pkg::dp_status_type       status,
   input  logic signed [DATA_WIDTH-1:0]  req_setpoint,
   input  logic signed [DATA_WIDTH-1:0]  req_position,
   input  logic signed [DATA_WIDTH-1:0]  req_rate,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_command
);
   import mmac_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int SW  = DW + 6;
   localparam int AW  = DW + 3;
   localparam int MD  = MUL_DIGIT_W;
   localparam int PW  = DW + COEF_W;
   localparam int XW  = DW + 1 + PERIOD_W;
   localparam int XW4 = ((XW + DIV_DIGIT_W - 1) / DIV_DIGIT_W) * DIV_DIGIT_W;
   localparam int NS  = XW4 / DIV_DIGIT_W;
   localparam int CW  = $clog2(NS);

   localparam logic signed [SW-1:0] VMAX_W = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [SW-1:0] VMIN_W = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic [PW-1:0] LIM_POS = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic [PW-1:0] LIM_NEG = LIM_POS + 1'b1;

   // Coefficients at FRAC_BITS fractional bits.
   localparam logic [COEF_W-1:0] C_LEAD_A   = COEF_W'(qc(32420, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LEAD_B   = COEF_W'(qc(30190, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LEAD_C   = COEF_W'(qc(6557, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LL_A     = COEF_W'(qc(32650, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LL_B     = COEF_W'(qc(62130, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LL_C     = COEF_W'(qc(29540, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LL_D     = COEF_W'(qc(16410, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_LL_E     = COEF_W'(qc(6463, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_SF_KP    = COEF_W'(qc(37616, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_SF_KV    = COEF_W'(qc(19724, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_SI_KI    = COEF_W'(qc(188082, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_SI_KP    = COEF_W'(qc(136236, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_SI_KV    = COEF_W'(qc(46107, FRAC_BITS));
   localparam logic [COEF_W-1:0] C_SI_RATIO = COEF_W'(si_ratio(FRAC_BITS));
   localparam logic signed [DW-1:0] THR     = DW'(qc(1745, FRAC_BITS));

   // Saturate a wide signed value to the data range.
   function automatic logic signed [DW-1:0] sat_w(input logic signed [SW-1:0] x);
      logic signed [DW-1:0] r;
      if (x > VMAX_W) begin
         r = VMAX_W[DW-1:0];
      end else if (x < VMIN_W) begin
         r = VMIN_W[DW-1:0];
      end else begin
         r = x[DW-1:0];
      end
      return r;
   endfunction

   // Captured word and working values.
   logic signed [DW-1:0] sp_ff, pos_ff, rate_ff, e_ff, u_ff, integ_ff;
   logic signed [DW-1:0] sp_in, pos_in, rate_in, e_in, u_in, integ_in;
   logic signed [AW-1:0] acc_ff, acc_in;

   // Law history, cleared by reset.
   logic signed [DW-1:0] pi_accum_ff, pi_accum_in, pi_last_ff, pi_last_in;
   logic signed [DW-1:0] err_prev_ff, err_prev_in, err_prev2_ff, err_prev2_in;
   logic signed [DW-1:0] cmd_prev_ff, cmd_prev_in, cmd_prev2_ff, cmd_prev2_in;
   logic signed [DW-1:0] integ_prev_ff, integ_prev_in;

   // Shared multiplier.
   logic [DW-1:0]        mul_a_ff, mul_a_in;
   logic [COEF_W-1:0]    mul_b_ff, mul_b_in;
   logic                 mul_neg_ff, mul_neg_in;
   logic [PW-1:0]        mul_p_ff, mul_p_in;
   logic [DW+MD-1:0]     mul_pp;
   logic [PW-1:0]        mul_sh, mul_mag;
   logic [DW-1:0]        mul_mag_n;
   logic signed [DW-1:0] mul_q;
   logic signed [DW-1:0] a_val;
   logic [COEF_W-1:0]    b_val;

   // Period divider.
   logic [XW4-1:0]       div_x_ff, div_x_in, div_x_step;
   logic [DIV_R_W-1:0]   div_r_ff, div_r_in, div_r_step;
   logic                 div_neg_ff, div_neg_in;
   logic [CW-1:0]        div_cnt_ff, div_cnt_in;
   logic signed [DW:0]   div_s;
   logic [DW:0]          div_mag;
   logic [XW-1:0]        div_prod;
   logic signed [DW:0]   scaled;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_command_ff, rsp_command_in;
   logic signed [DW-1:0] fin_cmd;
   logic signed [SW-1:0] speed_d, speed_w, pi_t, pi_w;

   // Multiplier data operand.
   always_comb begin
      unique case (cmd.a_sel)
         A_E:     a_val = e_ff;
         A_E1:    a_val = err_prev_ff;
         A_E2:    a_val = err_prev2_ff;
         A_C1:    a_val = cmd_prev_ff;
         A_C2:    a_val = cmd_prev2_ff;
         A_SP:    a_val = sp_ff;
         A_POS:   a_val = pos_ff;
         A_RATE:  a_val = rate_ff;
         A_INTEG: a_val = integ_ff;
         default: a_val = e_ff;
      endcase
   end

   // Multiplier coefficient operand; all coefficients are non-negative.
   always_comb begin
      unique case (cmd.b_sel)
         B_KI:       b_val = COEF_W'(cfg.integral_gain);
         B_LEAD_A:   b_val = C_LEAD_A;
         B_LEAD_B:   b_val = C_LEAD_B;
         B_LEAD_C:   b_val = C_LEAD_C;
         B_LL_A:     b_val = C_LL_A;
         B_LL_B:     b_val = C_LL_B;
         B_LL_C:     b_val = C_LL_C;
         B_LL_D:     b_val = C_LL_D;
         B_LL_E:     b_val = C_LL_E;
         B_SF_KP:    b_val = C_SF_KP;
         B_SF_KV:    b_val = C_SF_KV;
         B_SI_KI:    b_val = C_SI_KI;
         B_SI_KP:    b_val = C_SI_KP;
         B_SI_KV:    b_val = C_SI_KV;
         B_SI_RATIO: b_val = C_SI_RATIO;
         default:    b_val = C_LEAD_A;
      endcase
   end

   // One partial product per step: magnitude times one 16-bit coefficient digit.
   assign mul_pp = mul_a_ff * ((cmd.mul_op == MUL_HI) ? mul_b_ff[COEF_W-1:MD]
                                                       : mul_b_ff[MD-1:0]);

   // Drop the fraction, saturate the magnitude and restore the sign.
   always_comb begin
      mul_sh = mul_p_ff >> FRAC_BITS;
      if (mul_neg_ff) begin
         mul_mag = (mul_sh > LIM_NEG) ? LIM_NEG : mul_sh;
      end else begin
         mul_mag = (mul_sh > LIM_POS) ? LIM_POS : mul_sh;
      end
      mul_mag_n = mul_mag[DW-1:0];
      mul_q     = mul_neg_ff ? -signed'(mul_mag_n) : signed'(mul_mag_n);
   end

   // Divider source and its magnitude times the period.
   always_comb begin
      if (cfg.law_mode == MODE_PI) begin
         div_s = (DW+1)'(u_ff) + (DW+1)'(pi_last_ff);
      end else begin
         div_s = (DW+1)'(e_ff) + (DW+1)'(err_prev_ff);
      end
      div_mag  = div_s[DW] ? unsigned'(-div_s) : unsigned'(div_s);
      div_prod = div_mag * cfg.period_ms;
   end

   // Four restoring division steps by 2000; quotient bits shift in at the bottom.
   always_comb begin
      logic [DIV_R_W:0] rt;
      logic [XW4-1:0]   xt;
      rt = {1'b0, div_r_ff};
      xt = div_x_ff;
      for (int i = 0; i < DIV_DIGIT_W; i++) begin
         rt = {rt[DIV_R_W-1:0], xt[XW4-1]};
         xt = {xt[XW4-2:0], 1'b0};
         if (rt >= {1'b0, DIV_DIVISOR}) begin
            rt    = rt - {1'b0, DIV_DIVISOR};
            xt[0] = 1'b1;
         end
      end
      div_r_step = rt[DIV_R_W-1:0];
      div_x_step = xt;
   end

   // Scaled sum, truncated toward zero.
   assign scaled = div_neg_ff ? -signed'({1'b0, div_x_ff[DW-1:0]})
                              : signed'({1'b0, div_x_ff[DW-1:0]});

   // Command of each law.
   always_comb begin
      speed_d = SW'(sp_ff) - SW'(rate_ff);
      speed_w = speed_d * SW'(SPEED_GAIN);
      pi_t    = (SW'(e_ff) <<< 1) + SW'(pi_accum_ff) - SW'(rate_ff);
      pi_w    = pi_t <<< 1;
      case (cfg.law_mode)
         MODE_SPEED:                               fin_cmd = sat_w(speed_w);
         MODE_PI:                                  fin_cmd = sat_w(pi_w);
         MODE_LEAD, MODE_LEADLAG, MODE_SFB, MODE_SFB_INT: fin_cmd = sat_w(SW'(acc_ff));
         default:                                  fin_cmd = sp_ff;
      endcase
   end

   // Next values of all datapath registers.
   always_comb begin
      sp_in          = sp_ff;
      pos_in         = pos_ff;
      rate_in        = rate_ff;
      e_in           = e_ff;
      u_in           = u_ff;
      integ_in       = integ_ff;
      acc_in         = acc_ff;
      pi_accum_in    = pi_accum_ff;
      pi_last_in     = pi_last_ff;
      err_prev_in    = err_prev_ff;
      err_prev2_in   = err_prev2_ff;
      cmd_prev_in    = cmd_prev_ff;
      cmd_prev2_in   = cmd_prev2_ff;
      integ_prev_in  = integ_prev_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = mul_b_ff;
      mul_neg_in     = mul_neg_ff;
      mul_p_in       = mul_p_ff;
      div_x_in       = div_x_ff;
      div_r_in       = div_r_ff;
      div_neg_in     = div_neg_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_command_in = rsp_command_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      // Capture the input word.
      if (cmd.load) begin
         sp_in   = req_setpoint;
         pos_in  = req_position;
         rate_in = req_rate;
      end

      // Error and cleared sum.
      if (cmd.prep) begin
         e_in   = sat_w(SW'(sp_ff) - SW'(pos_ff));
         acc_in = '0;
      end

      // Multiplier steps.
      unique case (cmd.mul_op)
         MUL_LOAD: begin
            mul_a_in   = a_val[DW-1] ? (~unsigned'(a_val) + 1'b1) : unsigned'(a_val);
            mul_b_in   = b_val;
            mul_neg_in = a_val[DW-1];
         end
         MUL_LO: begin
            mul_p_in = {{MD{1'b0}}, mul_pp};
         end
         MUL_HI: begin
            mul_p_in = mul_p_ff + {mul_pp, {MD{1'b0}}};
         end
         MUL_DONE: begin
            unique case (cmd.dest)
               D_ADD:   acc_in   = acc_ff + AW'(mul_q);
               D_SUB:   acc_in   = acc_ff - AW'(mul_q);
               D_U:     u_in     = mul_q;
               D_INTEG: integ_in = mul_q;
               default: acc_in   = acc_ff;
            endcase
         end
         default: begin
         end
      endcase

      // Divider steps.
      unique case (cmd.div_op)
         DIV_LOAD: begin
            div_x_in   = XW4'(div_prod);
            div_r_in   = '0;
            div_neg_in = div_s[DW];
            div_cnt_in = '0;
         end
         DIV_RUN: begin
            div_x_in   = div_x_step;
            div_r_in   = div_r_step;
            div_cnt_in = status.div_last ? CW'(0) : div_cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase

      // Integrator updates once the scaled sum is ready.
      if (cmd.update) begin
         if (cfg.law_mode == MODE_PI) begin
            pi_accum_in = sat_w(SW'(pi_accum_ff) + SW'(scaled));
            pi_last_in  = u_ff;
         end else begin
            integ_in = sat_w(SW'(scaled) + SW'(integ_prev_ff));
         end
      end

      // Result word and history shift.
      if (cmd.finish) begin
         rsp_command_in = fin_cmd;
         rsp_valid_in   = 1'b1;
         case (cfg.law_mode)
            MODE_LEAD: begin
               cmd_prev_in = fin_cmd;
               err_prev_in = e_ff;
            end
            MODE_LEADLAG: begin
               cmd_prev2_in = cmd_prev_ff;
               err_prev2_in = err_prev_ff;
               cmd_prev_in  = fin_cmd;
               err_prev_in  = e_ff;
            end
            MODE_SFB_INT: begin
               integ_prev_in = integ_ff;
               err_prev_in   = e_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state and law history.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
         pi_accum_ff   <= '0;
         pi_last_ff    <= '0;
         err_prev_ff   <= '0;
         err_prev2_ff  <= '0;
         cmd_prev_ff   <= '0;
         cmd_prev2_ff  <= '0;
         integ_prev_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         div_cnt_ff    <= div_cnt_in;
         pi_accum_ff   <= pi_accum_in;
         pi_last_ff    <= pi_last_in;
         err_prev_ff   <= err_prev_in;
         err_prev2_ff  <= err_prev2_in;
         cmd_prev_ff   <= cmd_prev_in;
         cmd_prev2_ff  <= cmd_prev2_in;
         integ_prev_ff <= integ_prev_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      sp_ff          <= sp_in;
      pos_ff         <= pos_in;
      rate_ff        <= rate_in;
      e_ff           <= e_in;
      u_ff           <= u_in;
      integ_ff       <= integ_in;
      acc_ff         <= acc_in;
      mul_a_ff       <= mul_a_in;
      mul_b_ff       <= mul_b_in;
      mul_neg_ff     <= mul_neg_in;
      mul_p_ff       <= mul_p_in;
      div_x_ff       <= div_x_in;
      div_r_ff       <= div_r_in;
      div_neg_ff     <= div_neg_in;
      rsp_command_ff <= rsp_command_in;
   end

   assign status.div_last = (div_cnt_ff == CW'(NS - 1));
   assign status.e_over   = (e_ff > THR) || (e_ff < -THR);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;

`ifndef ASSERT_OFF
   // A result is only written into a free output register.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a word still waiting");

   // A finished result is offered in the next cycle.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not offered");

   // The upper coefficient digit always follows the lower one.
   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul_op == MUL_HI) |-> ($past(cmd.mul_op) == MUL_LO))
      else $error("multiplier upper step out of order");

   // A running division continues from a previous division step.
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_op == DIV_RUN && div_cnt_ff != '0) |-> ($past(cmd.div_op) == DIV_RUN))
      else $error("divider step count out of sequence");
`endif

endmodule

`default_nettype wire

/* rtl/multi_mode_attitude_controller_unit.sv */
// Top level of the multi-mode attitude controller.
`timescale 1ns / 1ps
`default_nettype none

// Multi-mode attitude controller. Each input word (setpoint, position, rate,
// signed fixed point with FRAC_BITS fractional bits) yields one saturated
// wheel command under the law selected in law_mode. The block works on one
// word at a time: req_stall is low only while it waits for a word, and a
// finished command waits in an output register so the next word can be taken.
// After a word is accepted the sequencer forms the error, then runs each
// product term through the multiplier steps (load, lower digit, upper
// digit, accumulate). PI runs its term before, and integrating state
// feedback runs its terms after, the period divider and the integrator
// update. The number of product terms per law is: open and speed loop 0,
// PI 1, lead 3, lead-lag 5, state feedback 2, integrating state feedback
// 3, or 4 when the error exceeds the threshold. The single shared
// multiplier steps through the coefficient 16 bits at a time; the period
// scaling takes four quotient bits a cycle. req_stall drops in the cycle
// in which the command is first offered, so the next word can be taken
// while that command waits; a stalled command holds the block
// until its output register is free. Registers sit at byte
// addresses 0 (law_mode), 4 (period_ms) and 8 (integral_gain) and should be
// written only while the block is idle; all law history is cleared by reset.
module multi_mode_attitude_controller_unit #(
   parameter int DATA_WIDTH = mmac_pkg::MMAC_DATA_WIDTH,
   parameter int FRAC_BITS  = mmac_pkg::MMAC_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_setpoint,
   input  logic signed [DATA_WIDTH-1:0]        req_position,
   input  logic signed [DATA_WIDTH-1:0]        req_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_command,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mmac_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mmac_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mmac_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import mmac_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Register file.
   mmac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Law sequencer.
   mmac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .law_mode  (cfg.law_mode),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and history.
   mmac_dp #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .req_setpoint (req_setpoint),
      .req_position (req_position),
      .req_rate     (req_rate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_command  (rsp_command)
   );

endmodule

`default_nettype wire

/* bench/multi_mode_attitude_controller_unit_tb.sv */
// Self-checking testbench of the multi-mode attitude controller: directed and random words.
`timescale 1ns / 1ps

module multi_mode_attitude_controller_unit_tb;
   import mmac_pkg::*;

   // Word format constants.
   localparam int FRAC = MMAC_FRAC_BITS;
   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam logic signed [31:0] Q_ONE = 32'sd65536;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] THR_WORD = 32'sd11436;
   localparam logic [GAIN_W-1:0] GAIN_ONE = 31'd65536;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 31'h7FFF_FFFF;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   // Decimal gain n/10000 rounded to nearest in the word format.
   function automatic longint q_dec(input longint n);
      return ((n <<< FRAC) + 64'sd5000) / 64'sd10000;
   endfunction

   localparam longint LEAD_A = q_dec(32420);
   localparam longint LEAD_B = q_dec(30190);
   localparam longint LEAD_C = q_dec(6557);
   localparam longint LL_A = q_dec(32650);
   localparam longint LL_B = q_dec(62130);
   localparam longint LL_C = q_dec(29540);
   localparam longint LL_D = q_dec(16410);
   localparam longint LL_E = q_dec(6463);
   localparam longint SF_KP = q_dec(37616);
   localparam longint SF_KV = q_dec(19724);
   localparam longint SI_KI = q_dec(188082);
   localparam longint SI_KP = q_dec(136236);
   localparam longint SI_KV = q_dec(46107);
   localparam longint SI_THR = q_dec(1745);
   localparam longint K_SI_RATIO = ((64'sd136236 <<< FRAC) + 64'sd94041) / 64'sd188082;

   // One row of the directed stimulus.
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [PERIOD_W-1:0] period;
      logic [GAIN_W-1:0]   gain;
      logic signed [31:0]  sp;
      logic signed [31:0]  pos;
      logic signed [31:0]  rate;
      logic                known;
      logic signed [31:0]  cmd;
   } word_case_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_setpoint = '0;
   logic signed [31:0] req_position = '0;
   logic signed [31:0] req_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_command;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Register copies and law history of the predictor.
   logic [MODE_W-1:0]   law_mode_q = MODE_OPEN;
   logic [PERIOD_W-1:0] period_q = 10'd10;
   logic [GAIN_W-1:0]   gain_q = GAIN_ONE;
   longint pi_acc = 0, pi_u_last = 0, err_d1 = 0, err_d2 = 0;
   longint cmd_d1 = 0, cmd_d2 = 0, integ_d1 = 0;

   logic signed [31:0] command_queue[$];
   logic signed [31:0] command_due;
   int idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int commands_checked = 0;
   int words_sent = 0;
   int configs_applied = 0;
   int drain_pauses = 0;

   word_case_type directed_cases [26] = '{
      // Reset settings: open loop passes the setpoint through.
      '{MODE_OPEN, 10'd10, GAIN_ONE, 32'sd0, 32'sd0, 32'sd0, 1'b1, 32'sd0},
      '{MODE_OPEN, 10'd10, GAIN_ONE, Q_MAX, Q_MIN, Q_MAX, 1'b1, Q_MAX},
      '{MODE_OPEN, 10'd10, GAIN_ONE, Q_MIN, Q_MAX, Q_MIN, 1'b1, Q_MIN},
      // Speed loop, both saturation directions and a plain gain of twelve.
      '{MODE_SPEED, 10'd10, GAIN_ONE, Q_MAX, 32'sd0, Q_MIN, 1'b1, Q_MAX},
      '{MODE_SPEED, 10'd10, GAIN_ONE, Q_MIN, 32'sd0, Q_MAX, 1'b1, Q_MIN},
      '{MODE_SPEED, 10'd10, GAIN_ONE, Q_ONE, 32'sd0, 32'sd0, 1'b1, 32'sd786432},
      // PI loop with extreme gains and periods, including period zero.
      '{MODE_PI, 10'd10, GAIN_ONE, Q_ONE, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      '{MODE_PI, 10'd10, GAIN_ONE, Q_MAX, Q_MIN, Q_MIN, 1'b0, 32'sd0},
      '{MODE_PI, 10'd1000, GAIN_MAX, Q_MIN, Q_MAX, Q_MAX, 1'b0, 32'sd0},
      '{MODE_PI, 10'd0, GAIN_MAX, Q_ONE, -Q_ONE, 32'sd0, 1'b0, 32'sd0},
      '{MODE_PI, 10'd1023, 31'd0, Q_ONE, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      // Lead and lead-lag with saturated errors.
      '{MODE_LEAD, 10'd10, GAIN_ONE, Q_ONE, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      '{MODE_LEAD, 10'd10, GAIN_ONE, Q_MAX, Q_MIN, 32'sd0, 1'b0, 32'sd0},
      '{MODE_LEAD, 10'd10, GAIN_ONE, Q_MIN, Q_MAX, 32'sd0, 1'b0, 32'sd0},
      '{MODE_LEADLAG, 10'd10, GAIN_ONE, Q_ONE, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      '{MODE_LEADLAG, 10'd10, GAIN_ONE, Q_MAX, Q_MIN, 32'sd0, 1'b0, 32'sd0},
      '{MODE_LEADLAG, 10'd10, GAIN_ONE, Q_MIN, Q_MAX, 32'sd0, 1'b0, 32'sd0},
      '{MODE_LEADLAG, 10'd10, GAIN_ONE, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      // State feedback driven into both rails.
      '{MODE_SFB, 10'd10, GAIN_ONE, Q_MAX, Q_MIN, Q_MIN, 1'b1, Q_MAX},
      '{MODE_SFB, 10'd10, GAIN_ONE, Q_MIN, Q_MAX, Q_MAX, 1'b1, Q_MIN},
      // Integrating state feedback on both sides of the error threshold.
      '{MODE_SFB_INT, 10'd10, GAIN_ONE, THR_WORD, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      '{MODE_SFB_INT, 10'd10, GAIN_ONE, THR_WORD + 1, 32'sd0, 32'sd0, 1'b0, 32'sd0},
      '{MODE_SFB_INT, 10'd10, GAIN_ONE, -THR_WORD, 32'sd0, Q_ONE, 1'b0, 32'sd0},
      '{MODE_SFB_INT, 10'd10, GAIN_ONE, 32'sd0, THR_WORD + 1, 32'sd0, 1'b0, 32'sd0},
      '{MODE_SFB_INT, 10'd1023, GAIN_ONE, Q_MAX, Q_MIN, Q_MIN, 1'b0, 32'sd0},
      // The unused law code behaves as open loop.
      '{MODE_UNUSED, 10'd1023, GAIN_ONE, 32'sd12345, Q_MAX, Q_MIN, 1'b1, 32'sd12345}
   };

   multi_mode_attitude_controller_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_setpoint (req_setpoint),
      .req_position (req_position),
      .req_rate     (req_rate),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_command  (rsp_command),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #10 clock = ~clock;

   // Saturate to the signed word range.
   function automatic longint clamp_word(input longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // Fixed-point product, truncated toward zero and saturated.
   function automatic longint fx_mul(input longint a, input longint b);
      bit neg;
      longint mag;
      longint lim;
      neg = (a < 0) != (b < 0);
      mag = ((a < 0) ? -a : a) * ((b < 0) ? -b : b);
      mag = mag >>> FRAC;
      lim = neg ? -WORD_MIN : WORD_MAX;
      if (mag > lim) mag = lim;
      return neg ? -mag : mag;
   endfunction

   // Integrator step: sum times the period in ms over two thousand, toward zero.
   function automatic longint scale_by_period(input longint sum);
      return sum * longint'(period_q) / 64'sd2000;
   endfunction

   // Wheel command of the selected law; advances the law history.
   function automatic logic signed [31:0] predict_command(input longint sp, input longint pos,
                                                          input longint rate);
      longint e;
      longint u;
      longint integ;
      longint cmd;
      e = clamp_word(sp - pos);
      case (law_mode_q)
         MODE_SPEED: begin
            cmd = clamp_word((sp - rate) * 12);
         end
         MODE_PI: begin
            u = fx_mul(e, longint'(gain_q));
            pi_acc = clamp_word(pi_acc + scale_by_period(u + pi_u_last));
            pi_u_last = u;
            cmd = clamp_word((2 * e + pi_acc - rate) * 2);
         end
         MODE_LEAD: begin
            cmd = clamp_word(fx_mul(LEAD_A, e) - fx_mul(LEAD_B, err_d1) + fx_mul(LEAD_C, cmd_d1));
            cmd_d1 = cmd;
            err_d1 = e;
         end
         MODE_LEADLAG: begin
            cmd = clamp_word(fx_mul(LL_A, e) - fx_mul(LL_B, err_d1) + fx_mul(LL_C, err_d2)
                             + fx_mul(LL_D, cmd_d1) - fx_mul(LL_E, cmd_d2));
            cmd_d2 = cmd_d1;
            err_d2 = err_d1;
            cmd_d1 = cmd;
            err_d1 = e;
         end
         MODE_SFB: begin
            cmd = clamp_word(fx_mul(SF_KP, e) - fx_mul(SF_KV, rate));
         end
         MODE_SFB_INT: begin
            integ = clamp_word(scale_by_period(e + err_d1) + integ_d1);
            // A large error reloads the integrator from the setpoint.
            if (e > SI_THR || e < -SI_THR) integ = fx_mul(sp, K_SI_RATIO);
            cmd = clamp_word(fx_mul(SI_KI, integ) - fx_mul(SI_KP, pos) - fx_mul(SI_KV, rate));
            integ_d1 = integ;
            err_d1 = e;
         end
         default: begin
            cmd = sp;
         end
      endcase
      return cmd[31:0];
   endfunction

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Hold the sender until every expected command has been returned.
   task automatic drain_commands();
      req_valid <= 1'b0;
      while (command_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers with the block idle.
   task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [PERIOD_W-1:0] period,
                               input logic [GAIN_W-1:0] gain);
      drain_commands();
      csr_write(REG_LAW_MODE, {{(CSR_DATA_W-MODE_W){1'b0}}, mode});
      csr_write(REG_PERIOD, {{(CSR_DATA_W-PERIOD_W){1'b0}}, period});
      csr_write(REG_GAIN, {{(CSR_DATA_W-GAIN_W){1'b0}}, gain});
      law_mode_q = mode;
      period_q = period;
      gain_q = gain;
      configs_applied++;
   endtask

   // Offer one word, record its command, then idle at random.
   task automatic send_word(input logic signed [31:0] sp, input logic signed [31:0] pos,
                            input logic signed [31:0] rate, input logic known,
                            input logic signed [31:0] cmd_known);
      logic signed [31:0] predicted;
      req_valid <= 1'b1;
      req_setpoint <= sp;
      req_position <= pos;
      req_rate <= rate;
      do @(posedge clock); while (req_stall);
      predicted = predict_command(sp, pos, rate);
      command_queue.push_back(known ? cmd_known : predicted);
      words_sent++;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Uniform value in [-span, span].
   function automatic logic signed [31:0] small_q(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [31:0] extreme_q();
      case ($urandom_range(5))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return 32'sd0;
         3: return 32'sd1;
         4: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Plausible tracking words in the largest share, some near the threshold, some wild.
   task automatic pick_word(output logic signed [31:0] sp, output logic signed [31:0] pos,
                            output logic signed [31:0] rate);
      int kind;
      kind = $urandom_range(99);
      if (kind < 45) begin
         sp = small_q(262144);
         pos = sp - small_q(20000);
         rate = small_q(131072);
      end else if (kind < 65) begin
         sp = small_q(262144);
         pos = sp - ($urandom_range(1) ? THR_WORD : -THR_WORD) - small_q(2);
         rate = small_q(131072);
      end else if (kind < 85) begin
         sp = $urandom;
         pos = $urandom;
         rate = $urandom;
      end else begin
         sp = extreme_q();
         pos = extreme_q();
         rate = extreme_q();
      end
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Compare every returned word with the oldest expected command.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (command_queue.size() == 0) begin
            $error("command returned with none expected: actual %0d", rsp_command);
            mismatch_count++;
         end else begin
            command_due = command_queue.pop_front();
            commands_checked++;
            if (rsp_command !== command_due) begin
               $error("command mismatch: expected %0d, actual %0d", command_due, rsp_command);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence: reset, directed rows, four traffic profiles of random words.
   initial begin
      word_case_type dc;
      logic signed [31:0] sp, pos, rate;
      logic [PERIOD_W-1:0] period;
      logic [GAIN_W-1:0] gain;
      int pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[i]) begin
         dc = directed_cases[i];
         if (dc.mode != law_mode_q || dc.period != period_q || dc.gain != gain_q)
            apply_config(dc.mode, dc.period, dc.gain);
         send_word(dc.sp, dc.pos, dc.rate, dc.known, dc.cmd);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 48; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 48; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (int blk = 0; blk < 6; blk++) begin
            pick = $urandom_range(9);
            case (pick)
               0: period = 10'd0;
               1: period = 10'd1;
               2: period = 10'd1000;
               3: period = 10'd1023;
               default: period = PERIOD_W'($urandom_range(1, 1000));
            endcase
            pick = $urandom_range(9);
            case (pick)
               0: gain = 31'd0;
               1: gain = GAIN_MAX;
               2: gain = GAIN_ONE;
               3, 4, 5: gain = GAIN_W'($urandom_range(0, 262144));
               default: gain = GAIN_W'($urandom);
            endcase
            apply_config(MODE_W'($urandom_range(7)), period, gain);
            for (int k = 0; k < 50; k++) begin
               // Now and then let the pipeline run dry before the next word.
               if ($urandom_range(39) == 0) begin
                  drain_commands();
                  drain_pauses++;
               end
               pick_word(sp, pos, rate);
               send_word(sp, pos, rate, 1'b0, 32'sd0);
            end
         end
      end

      drain_commands();
      repeat (48) @(posedge clock);
      $display("Sent %0d words under %0d register settings and four traffic profiles,",
               words_sent, configs_applied);
      $display("with %0d full drains; %0d commands compared.", drain_pauses, commands_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #16_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mmac_pkg.sv
rtl/mmac_csr.sv
rtl/mmac_ctrl.sv
rtl/mmac_dp.sv
rtl/multi_mode_attitude_controller_unit.sv
bench/multi_mode_attitude_controller_unit_tb.sv
